/* rtl/sfd_pkg.sv */
// Shared types and constants for the stereo feedback delay.
package sfd_pkg;

  // Ring geometry: address width sets the ring depth in frames.
  localparam int RING_AW     = 15;
  localparam int RING_FRAMES = 1 << RING_AW;

  // Q1.15 unity gain and sample width.
  localparam int          SAMPLE_W = 16;
  localparam int          GAIN_W   = 17;
  localparam logic [16:0] Q_ONE    = 17'd32768;

  // Configuration register indexes.
  localparam int          CFG_IDX_W    = 2;
  localparam logic [1:0]  CFG_DELAY    = 2'd0;
  localparam logic [1:0]  CFG_WET      = 2'd1;
  localparam logic [1:0]  CFG_FEEDBACK = 2'd2;

  // Register reset values.
  localparam logic [15:0] DELAY_RST    = 16'd12000;
  localparam logic [15:0] WET_RST      = 16'd16384;
  localparam logic [15:0] FEEDBACK_RST = 16'd16384;

  // One input beat: a stereo frame.
  typedef struct packed {
    logic signed [15:0] in_right;
    logic signed [15:0] in_left;
  } in_t;

  // One output beat: a mixed stereo frame.
  typedef struct packed {
    logic signed [15:0] out_right;
    logic signed [15:0] out_left;
  } out_t;

  // Ring write request: right sample in the upper half, left in the lower.
  typedef struct packed {
    logic                en;
    logic [RING_AW-1:0]  addr;
    logic [31:0]         data;
  } ring_wr_t;

endpackage

/* rtl/sfd_ring.sv */
// Frame ring memory: one write port, one registered read port.
module sfd_ring (
  input  logic                          clk,
  input  sfd_pkg::ring_wr_t             wr,
  input  logic                          rd_en,
  input  logic [sfd_pkg::RING_AW-1:0]   rd_addr,
  output logic [31:0]                   rd_data
);

  logic [31:0] mem [sfd_pkg::RING_FRAMES];

  // Write the stored frame.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read the delayed frame; old data wins on a same-edge collision.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/sfd_lane.sv */
// One channel lane: registered gain products, then round and saturate.
module sfd_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0]  x,
  input  logic signed [sfd_pkg::SAMPLE_W-1:0]  d,
  input  logic        [sfd_pkg::GAIN_W-1:0]    wet,
  input  logic        [sfd_pkg::GAIN_W-1:0]    fb,
  output logic signed [sfd_pkg::SAMPLE_W-1:0]  mix,
  output logic signed [sfd_pkg::SAMPLE_W-1:0]  store
);

  logic signed [17:0] dry_coef;
  logic signed [17:0] wet_coef;
  logic signed [17:0] fb_coef;
  logic signed [33:0] dry_prod;
  logic signed [33:0] wet_prod;
  logic signed [33:0] fb_prod;
  logic signed [15:0] x_q;
  logic signed [33:0] mix_acc;
  logic signed [33:0] store_acc;

  // Round Q4.30 to nearest (ties up) and saturate to Q1.15.
  function automatic logic signed [15:0] to_q15(input logic signed [33:0] acc);
    logic signed [33:0] biased;
    logic signed [18:0] r;
    begin
      biased = acc + 34'sd16384;
      r      = biased[33:15];
      if (r > 19'sd32767) begin
        to_q15 = 16'sh7FFF;
      end else if (r < -19'sd32768) begin
        to_q15 = 16'sh8000;
      end else begin
        to_q15 = r[15:0];
      end
    end
  endfunction

  assign dry_coef = $signed({1'b0, sfd_pkg::Q_ONE - wet});
  assign wet_coef = $signed({1'b0, wet});
  assign fb_coef  = $signed({1'b0, fb});

  // Register the products.
  always_ff @(posedge clk) begin
    if (en) begin
      dry_prod <= dry_coef * x;
      wet_prod <= wet_coef * d;
      fb_prod  <= fb_coef * d;
      x_q      <= x;
    end
  end

  // Sum, round and saturate.
  assign mix_acc   = dry_prod + wet_prod;
  assign store_acc = {{3{x_q[15]}}, x_q, 15'd0} + fb_prod;
  assign mix       = to_q15(mix_acc);
  assign store     = to_q15(store_acc);

endmodule

/* rtl/stereo_feedback_delay.sv */
// Top level of the stereo feedback delay: control, ring, lanes and output merge.
//
// Stereo echo with feedback and dry/wet mix in Q1.15. Each input beat is one
// stereo frame; each produces exactly one output beat, after the input stage,
// the lane product registers and the output register. Frames are taken one
// per cycle while the output is not stalled: the ring is read at acceptance
// and written when the frame leaves the product stage, so a delay of one or
// two frames makes a new frame wait for the write-back it depends on.
// The ring holds 32768 frames and reads as zero until written; no clearing
// pass is needed after reset. Delay is taken modulo the ring size (zero acts
// as a full ring); wet and feedback gains above 32768 act as 32768.
// Configuration registers: 0 delay in frames, 1 wet mix, 2 feedback gain.
// Write them only while the block is idle.
module stereo_feedback_delay (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  sfd_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output sfd_pkg::out_t                      out_data,
  input  logic                               cfg_write,
  input  logic [sfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                        cfg_data
);

  logic [15:0]                  delay_frames;
  logic [15:0]                  wet_mix;
  logic [15:0]                  feedback_gain;
  logic [sfd_pkg::GAIN_W-1:0]   wet_gain;
  logic [sfd_pkg::GAIN_W-1:0]   fb_gain;

  logic [sfd_pkg::RING_AW-1:0]  wp;
  logic                         wrapped;
  logic [sfd_pkg::RING_AW-1:0]  rd_addr;
  logic                         hazard;
  logic                         adv;
  logic                         in_accept;

  logic                         s1_valid;
  logic [sfd_pkg::RING_AW-1:0]  s1_wp;
  logic                         s1_hit;
  sfd_pkg::in_t                 s1_x;
  logic                         s2_valid;
  logic [sfd_pkg::RING_AW-1:0]  s2_wp;

  logic [31:0]                  rd_data;
  logic [31:0]                  d_frame;
  sfd_pkg::ring_wr_t            ring_wr;
  logic signed [15:0]           mix_l;
  logic signed [15:0]           mix_r;
  logic signed [15:0]           store_l;
  logic signed [15:0]           store_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_frames  <= sfd_pkg::DELAY_RST;
      wet_mix       <= sfd_pkg::WET_RST;
      feedback_gain <= sfd_pkg::FEEDBACK_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sfd_pkg::CFG_DELAY:    delay_frames  <= cfg_data;
        sfd_pkg::CFG_WET:      wet_mix       <= cfg_data;
        sfd_pkg::CFG_FEEDBACK: feedback_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp gains to unity.
  assign wet_gain = ({1'b0, wet_mix} > sfd_pkg::Q_ONE) ? sfd_pkg::Q_ONE
                                                       : {1'b0, wet_mix};
  assign fb_gain  = ({1'b0, feedback_gain} > sfd_pkg::Q_ONE) ? sfd_pkg::Q_ONE
                                                             : {1'b0, feedback_gain};

  // Read address and hazard against frames not yet written back.
  assign rd_addr   = wp - delay_frames[sfd_pkg::RING_AW-1:0];
  assign hazard    = (s1_valid && (rd_addr == s1_wp)) || (s2_valid && (rd_addr == s2_wp));
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv || hazard;
  assign in_accept = in_valid && !in_stall;

  // Advance write position; note the first wrap.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
    end else if (in_accept) begin
      wp <= wp + 1'b1;
      if (wp == {sfd_pkg::RING_AW{1'b1}}) begin
        wrapped <= 1'b1;
      end
    end
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= in_accept;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_x   <= in_data;
      s1_wp  <= wp;
      s1_hit <= wrapped || (rd_addr < wp);
    end
    if (adv) begin
      s2_wp <= s1_wp;
    end
  end

  sfd_ring u_ring (
    .clk     (clk),
    .wr      (ring_wr),
    .rd_en   (in_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Unwritten entries read as silence.
  assign d_frame = s1_hit ? rd_data : 32'd0;

  sfd_lane u_lane_left (
    .clk   (clk),
    .en    (adv),
    .x     (s1_x.in_left),
    .d     ($signed(d_frame[15:0])),
    .wet   (wet_gain),
    .fb    (fb_gain),
    .mix   (mix_l),
    .store (store_l)
  );

  sfd_lane u_lane_right (
    .clk   (clk),
    .en    (adv),
    .x     (s1_x.in_right),
    .d     ($signed(d_frame[31:16])),
    .wet   (wet_gain),
    .fb    (fb_gain),
    .mix   (mix_r),
    .store (store_r)
  );

  // Merge lanes: write back the stored frame as the beat leaves.
  assign ring_wr.en   = adv && s2_valid;
  assign ring_wr.addr = s2_wp;
  assign ring_wr.data = {store_r, store_l};

  // Hold the output beat until taken.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_left  <= mix_l;
      out_data.out_right <= mix_r;
    end
  end

endmodule
